### hw/rtl/numeric_integration_1d_defines.svh
// Assertion macros shared by the numeric integration block.
`ifndef NUMERIC_INTEGRATION_1D_DEFINES_SVH
`define NUMERIC_INTEGRATION_1D_DEFINES_SVH

// Check a consequence in the same cycle as its antecedent.
`define NINT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its antecedent.
`define NINT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/nint_pkg.sv
// Types and constants shared by the numeric integration block.
package nint_pkg;

  // Fixed field widths
  localparam int SAMPLE_W = 32;
  localparam int COORD_W  = 32;
  localparam int OUT_W    = 64;
  localparam int ICNT_W   = 17;
  localparam int CFG_W    = 32;
  localparam int CFG_IDX_W = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_X_START  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_X_END    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 2'd3;

  // Mode codes
  localparam logic MODE_TRAP    = 1'b0;
  localparam logic MODE_SIMPSON = 1'b1;

  // Clamp values of the result
  localparam logic [OUT_W-1:0] RES_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] RES_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  // Sequencer of the final scale step
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NUM1,
    ST_NUM2,
    ST_DIFF,
    ST_MAGN,
    ST_MAGD,
    ST_DVSR,
    ST_MUL,
    ST_DIV,
    ST_CMP,
    ST_RND,
    ST_SAT,
    ST_DONE
  } nint_state_t;

  // Top level to scale unit
  typedef struct packed {
    logic start;
    logic take;
  } nint_ctrl_t;

  // Scale unit to top level
  typedef struct packed {
    logic idle;
    logic done;
  } nint_status_t;

endpackage

### hw/rtl/nint_if.sv
// Stream interfaces for the sample and result channels.
interface nint_in_if;
  import nint_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface nint_out_if;
  import nint_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] integral;
  logic                    saturated;

  modport source (output valid, output integral, output saturated, input ready);
  modport sink   (input valid, input integral, input saturated, output ready);
endinterface

### hw/rtl/numeric_integration_1d.sv
// Top level of the streaming 1D trapezoid/Simpson integrator.
`include "numeric_integration_1d_defines.svh"

// A run is N+1 samples, taken one beat per cycle while the block is ready.
// Each sample is weighted and added to the Simpson sum, the trapezoid sum
// or both in the cycle it is accepted. After the last sample a shared
// adder under a small sequencer forms the scaled result: setup of the
// numerator, the bound difference, their magnitudes and the divisor, a
// shift-add multiply, a restoring divide over the PROD_W-bit product
// (PROD_W = clog2(MAX_INTERVALS+1) + 71, 88 at the default MAX_INTERVALS),
// rounding and clamping, and a done state that hands the result to the
// output register. Input ready is low from the last sample of a run until
// that handover, longer while an earlier result still waits there. The
// result sits there, so the next run may start while it waits to be taken.
module numeric_integration_1d #(
  parameter int MAX_INTERVALS = 65536
) (
  input  logic                              clk,
  input  logic                              rst_n,
  nint_in_if.sink                           in_chan,
  nint_out_if.source                        out_chan,
  input  logic                              cfg_we,
  input  logic [nint_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [nint_pkg::CFG_W-1:0]        cfg_wdata
);
  import nint_pkg::*;

  localparam int IDX_W  = $clog2(MAX_INTERVALS+1);
  localparam int SUM_W  = IDX_W + 35;
  localparam int NCMP_W = (IDX_W > ICNT_W) ? IDX_W : ICNT_W;

  // Per-sample weight codes
  typedef enum logic [1:0] {
    WT_0,
    WT_1,
    WT_2,
    WT_4
  } weight_t;

  // Configuration registers
  logic                       mode_r;
  logic signed [COORD_W-1:0]  x_start_r;
  logic signed [COORD_W-1:0]  x_end_r;
  logic [ICNT_W-1:0]          icnt_r;

  // Run state
  logic signed [SUM_W-1:0]    simpson_r, simpson_nxt;
  logic signed [SUM_W-1:0]    trap_r, trap_nxt;
  logic [IDX_W-1:0]           idx_r;

  // Output register
  logic                       out_valid_r;
  logic [OUT_W-1:0]           integral_r;
  logic                       saturated_r;

  logic [NCMP_W-1:0]          n_cmp;
  logic [IDX_W-1:0]           n_eff, m_cnt, i_pos;
  logic                       last;
  logic                       in_acc;
  weight_t                    s_wt, t_wt;
  logic signed [SUM_W-1:0]    f_ext, s_add, t_add;

  nint_ctrl_t                 ctrl;
  nint_status_t               status;
  logic [OUT_W-1:0]           res;
  logic                       res_sat;

  logic                       run_empty;
  logic                       res_clamped;

  // Take configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_TRAP;
      x_start_r <= '0;
      x_end_r   <= COORD_W'(65536);
      icnt_r    <= ICNT_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODE:     mode_r    <= cfg_wdata[0];
        CFG_X_START:  x_start_r <= cfg_wdata[COORD_W-1:0];
        CFG_X_END:    x_end_r   <= cfg_wdata[COORD_W-1:0];
        CFG_INTERVAL: icnt_r    <= cfg_wdata[ICNT_W-1:0];
        default:      mode_r    <= mode_r;
      endcase
    end
  end

  // Clamp N into 1..MAX_INTERVALS
  always_comb begin
    if (icnt_r == '0) begin
      n_cmp = NCMP_W'(1);
    end else if (NCMP_W'(icnt_r) > NCMP_W'(MAX_INTERVALS)) begin
      n_cmp = NCMP_W'(MAX_INTERVALS);
    end else begin
      n_cmp = NCMP_W'(icnt_r);
    end
  end

  assign n_eff = n_cmp[IDX_W-1:0];
  assign m_cnt = n_eff[0] ? n_eff - 1'b1 : n_eff;
  assign last  = (idx_r >= n_eff);
  assign i_pos = last ? n_eff : idx_r;

  assign in_chan.ready = status.idle;
  assign in_acc        = in_chan.valid & status.idle;

  // Pick the weights of this sample
  always_comb begin
    s_wt = WT_0;
    t_wt = WT_0;
    if (mode_r == MODE_TRAP) begin
      t_wt = (i_pos == '0 || i_pos == n_eff) ? WT_1 : WT_2;
    end else begin
      if (m_cnt != '0 && i_pos <= m_cnt) begin
        if (i_pos == '0 || i_pos == m_cnt) s_wt = WT_1;
        else if (i_pos[0]) s_wt = WT_4;
        else s_wt = WT_2;
      end
      // trapezoid panel on the last interval of an odd count
      if (n_eff[0] && i_pos >= m_cnt) t_wt = WT_1;
    end
  end

  assign f_ext = {{(SUM_W-SAMPLE_W){in_chan.sample[SAMPLE_W-1]}}, in_chan.sample};

  always_comb begin
    case (s_wt)
      WT_1:    s_add = f_ext;
      WT_2:    s_add = f_ext <<< 1;
      WT_4:    s_add = f_ext <<< 2;
      default: s_add = '0;
    endcase
    case (t_wt)
      WT_1:    t_add = f_ext;
      WT_2:    t_add = f_ext <<< 1;
      WT_4:    t_add = f_ext <<< 2;
      default: t_add = '0;
    endcase
  end

  assign simpson_nxt = simpson_r + s_add;
  assign trap_nxt    = trap_r + t_add;

  // Accumulate samples; clear at the end of a run
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      simpson_r <= '0;
      trap_r    <= '0;
      idx_r     <= '0;
    end else if (in_acc) begin
      if (last) begin
        simpson_r <= '0;
        trap_r    <= '0;
        idx_r     <= '0;
      end else begin
        simpson_r <= simpson_nxt;
        trap_r    <= trap_nxt;
        idx_r     <= i_pos + 1'b1;
      end
    end
  end

  assign ctrl.start = in_acc & last;
  assign ctrl.take  = status.done & (~out_valid_r | out_chan.ready);

  nint_scale #(
    .MAX_INTERVALS (MAX_INTERVALS)
  ) u_scale (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctrl          (ctrl),
    .simpson_sum   (simpson_nxt),
    .trapezoid_sum (trap_nxt),
    .x_start       (x_start_r),
    .x_end         (x_end_r),
    .n_eff         (n_eff),
    .status        (status),
    .integral      (res),
    .saturated     (res_sat)
  );

  // Hold the result until the sink takes the beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.take) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.take) begin
      integral_r  <= res;
      saturated_r <= res_sat;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.integral  = integral_r;
  assign out_chan.saturated = saturated_r;

  // Checks
  assign run_empty   = (idx_r == '0) && (simpson_r == '0) && (trap_r == '0);
  assign res_clamped = (integral_r == RES_MAX) || (integral_r == RES_MIN);

  `NINT_ASSERT_NEXT(a_start_busy, ctrl.start, !status.idle, "scale unit idle after start")
  `NINT_ASSERT_NEXT(a_run_clear, in_acc && last, run_empty, "run state not cleared")
  `NINT_ASSERT_SAME(a_sat_clamp, out_valid_r && saturated_r, res_clamped, "result not clamped")

endmodule

### hw/rtl/nint_scale.sv
// Sequenced scale unit: (x_end - x_start) * (2*S + 3*T) / (6*N), rounded and clamped.
module nint_scale #(
  parameter int MAX_INTERVALS = 65536
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  nint_pkg::nint_ctrl_t                 ctrl,
  input  logic signed [$clog2(MAX_INTERVALS+1)+34:0] simpson_sum,
  input  logic signed [$clog2(MAX_INTERVALS+1)+34:0] trapezoid_sum,
  input  logic signed [nint_pkg::COORD_W-1:0]  x_start,
  input  logic signed [nint_pkg::COORD_W-1:0]  x_end,
  input  logic [$clog2(MAX_INTERVALS+1)-1:0]   n_eff,
  output nint_pkg::nint_status_t               status,
  output logic [nint_pkg::OUT_W-1:0]           integral,
  output logic                                 saturated
);
  import nint_pkg::*;

  localparam int IDX_W  = $clog2(MAX_INTERVALS+1);
  localparam int SUM_W  = IDX_W + 35;
  localparam int NUM_W  = SUM_W + 3;
  localparam int MAG_W  = COORD_W + 1;
  localparam int PROD_W = NUM_W + MAG_W;
  localparam int D_W    = $clog2(6*MAX_INTERVALS+1);
  localparam int ALU_W  = PROD_W + 1;
  localparam int CNT_W  = $clog2(PROD_W+1);
  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MAG_W-1);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(PROD_W-1);

  nint_state_t state_r, state_nxt;

  logic signed [SUM_W-1:0] s_r, t_r;
  logic [NUM_W-1:0]        a_r;
  logic [MAG_W-1:0]        b_r;
  logic [PROD_W-1:0]       p_r;
  logic [D_W-1:0]          rem_r;
  logic [D_W-1:0]          d_r;
  logic [CNT_W-1:0]        cnt_r;
  logic                    neg_r;
  logic                    rnd_r;
  logic [OUT_W-1:0]        res_r;
  logic                    sat_r;

  // Shared adder/subtractor
  logic [ALU_W-1:0] alu_a, alu_b, alu_y;
  logic             alu_sub;

  logic [D_W:0]     rem_sh;
  logic             div_ge;
  logic             pos_ovf, neg_ovf;

  assign alu_y   = alu_a + (alu_sub ? ~alu_b : alu_b) + ALU_W'(alu_sub);
  assign rem_sh  = {rem_r, p_r[PROD_W-1]};
  assign div_ge  = ~alu_y[ALU_W-1];
  assign pos_ovf = |p_r[PROD_W-1:OUT_W-1];
  assign neg_ovf = (|p_r[PROD_W-1:OUT_W]) | (p_r[OUT_W-1] & (|p_r[OUT_W-2:0]));

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (ctrl.start) state_nxt = ST_NUM1;
      ST_NUM1: state_nxt = ST_NUM2;
      ST_NUM2: state_nxt = ST_DIFF;
      ST_DIFF: state_nxt = ST_MAGN;
      ST_MAGN: state_nxt = ST_MAGD;
      ST_MAGD: state_nxt = ST_DVSR;
      ST_DVSR: state_nxt = ST_MUL;
      ST_MUL:  if (cnt_r == MUL_LAST) state_nxt = ST_DIV;
      ST_DIV:  if (cnt_r == DIV_LAST) state_nxt = ST_CMP;
      ST_CMP:  state_nxt = ST_RND;
      ST_RND:  state_nxt = ST_SAT;
      ST_SAT:  state_nxt = ST_DONE;
      ST_DONE: if (ctrl.take) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Status and adder operands
  always_comb begin
    status.idle = (state_r == ST_IDLE);
    status.done = (state_r == ST_DONE);
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state_r)
      ST_NUM1: begin
        alu_a = {{(ALU_W-SUM_W){s_r[SUM_W-1]}}, s_r};
        alu_b = {{(ALU_W-SUM_W){t_r[SUM_W-1]}}, t_r};
      end
      ST_NUM2: begin
        alu_a = {{(ALU_W-NUM_W){a_r[NUM_W-1]}}, a_r} << 1;
        alu_b = {{(ALU_W-SUM_W){t_r[SUM_W-1]}}, t_r};
      end
      ST_DIFF: begin
        alu_a   = {{(ALU_W-COORD_W){x_end[COORD_W-1]}}, x_end};
        alu_b   = {{(ALU_W-COORD_W){x_start[COORD_W-1]}}, x_start};
        alu_sub = 1'b1;
      end
      ST_MAGN: begin
        alu_b   = {{(ALU_W-NUM_W){a_r[NUM_W-1]}}, a_r};
        alu_sub = 1'b1;
      end
      ST_MAGD: begin
        alu_b   = {{(ALU_W-MAG_W){b_r[MAG_W-1]}}, b_r};
        alu_sub = 1'b1;
      end
      ST_DVSR: begin
        alu_a = ALU_W'(n_eff) << 2;
        alu_b = ALU_W'(n_eff) << 1;
      end
      ST_MUL: begin
        alu_a = ALU_W'(p_r) << 1;
        alu_b = b_r[MAG_W-1] ? ALU_W'(a_r) : '0;
      end
      ST_DIV: begin
        alu_a   = ALU_W'(rem_sh);
        alu_b   = ALU_W'(d_r);
        alu_sub = 1'b1;
      end
      ST_CMP: begin
        alu_a   = ALU_W'({rem_r, 1'b0});
        alu_b   = ALU_W'(d_r);
        alu_sub = 1'b1;
      end
      ST_RND: begin
        alu_a = ALU_W'(p_r);
        alu_b = ALU_W'(rnd_r);
      end
      ST_SAT: begin
        alu_b   = ALU_W'(p_r);
        alu_sub = 1'b1;
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  // Advance the sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (ctrl.start) begin
          s_r <= simpson_sum;
          t_r <= trapezoid_sum;
        end
      end
      ST_NUM1, ST_NUM2: a_r <= alu_y[NUM_W-1:0];
      ST_DIFF: b_r <= alu_y[MAG_W-1:0];
      ST_MAGN: begin
        neg_r <= a_r[NUM_W-1] ^ b_r[MAG_W-1];
        if (a_r[NUM_W-1]) a_r <= alu_y[NUM_W-1:0];
      end
      ST_MAGD: begin
        if (b_r[MAG_W-1]) b_r <= alu_y[MAG_W-1:0];
      end
      ST_DVSR: begin
        d_r   <= alu_y[D_W-1:0];
        p_r   <= '0;
        cnt_r <= '0;
      end
      ST_MUL: begin
        // shift-add, multiplier bits from the top
        p_r   <= alu_y[PROD_W-1:0];
        b_r   <= b_r << 1;
        rem_r <= '0;
        cnt_r <= (cnt_r == MUL_LAST) ? '0 : cnt_r + 1'b1;
      end
      ST_DIV: begin
        // restoring division, quotient bits shift in behind the dividend
        rem_r <= div_ge ? alu_y[D_W-1:0] : rem_sh[D_W-1:0];
        p_r   <= {p_r[PROD_W-2:0], div_ge};
        cnt_r <= cnt_r + 1'b1;
      end
      ST_CMP: rnd_r <= div_ge;
      ST_RND: p_r <= alu_y[PROD_W-1:0];
      ST_SAT: begin
        if (!neg_r) begin
          sat_r <= pos_ovf;
          res_r <= pos_ovf ? RES_MAX : p_r[OUT_W-1:0];
        end else begin
          sat_r <= neg_ovf;
          res_r <= neg_ovf ? RES_MIN : alu_y[OUT_W-1:0];
        end
      end
      default: begin
        res_r <= res_r;
      end
    endcase
  end

  assign integral  = res_r;
  assign saturated = sat_r;

endmodule

### tb/sv/tb_numeric_integration_1d.sv
// Self-checking testbench for the streaming 1D trapezoid/Simpson integrator.
`timescale 1ns / 100ps

module tb_numeric_integration_1d;
  import nint_pkg::*;

  localparam int MAX_N         = 65536;
  localparam int SETTLE_CYCLES = 200;  // covers the scale step
  localparam int RANDOM_ITEMS  = 680;

  typedef struct packed {
    logic [OUT_W-1:0] integral;
    logic             saturated;
  } integral_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  nint_in_if  in_chan ();
  nint_out_if out_chan ();

  numeric_integration_1d #(.MAX_INTERVALS(MAX_N)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Register copies, at their reset values
  logic              mode_q    = MODE_TRAP;
  int                x_start_q = 0;
  int                x_end_q   = 32'h0001_0000;
  logic [ICNT_W-1:0] icnt_q    = ICNT_W'(1);

  // Weighted sums of the run in progress
  longint      simpson_acc   = 0;
  longint      trapezoid_acc = 0;
  int unsigned grid_index    = 0;

  logic [SAMPLE_W-1:0] pending_samples[$];
  integral_t           expected_integrals[$];
  integral_t           want;
  int                  mismatch_count = 0;
  int                  random_samples = 0;
  int                  src_gap;
  int                  sink_stall;
  bit                  idle_en = 1'b1;

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  function automatic int pick_gap(input bit en);
    int r;
    if (!en) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(13, 40);
  endfunction

  // Q16.16 value: extremes, values near zero, or anything
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 2) - 1;
      3, 4, 5, 6: return $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
      default: return $urandom();
    endcase
  endfunction

  // Mostly short runs, a few zero, long or oversized counts
  function automatic logic [ICNT_W-1:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return ICNT_W'($urandom_range(1, 8));
    if (r < 88) return ICNT_W'($urandom_range(9, 48));
    if (r < 92) return '0;
    return ICNT_W'($urandom_range(49, 131071));
  endfunction

  function automatic int unsigned eff_intervals(input logic [ICNT_W-1:0] c);
    if (c == 0) return 1;
    if (c > MAX_N) return MAX_N;
    return c;
  endfunction

  // Scale (x_end - x_start) * (2S + 3T) / 6N into Q32.32, round half away, clamp
  function automatic integral_t scale_integral(input longint simp, input longint trap,
                                               input int unsigned n);
    longint       num;
    longint       diff;
    bit           neg;
    logic [127:0] prod;
    logic [127:0] dvs;
    logic [127:0] quo;
    logic [127:0] rem;
    integral_t    r;
    num  = 2 * simp + 3 * trap;
    diff = longint'(x_end_q) - longint'(x_start_q);
    neg  = (num < 0) != (diff < 0);
    prod = {64'd0, num < 0 ? -num : num} * {64'd0, diff < 0 ? -diff : diff};
    dvs  = 128'(n) * 6;
    quo  = prod / dvs;
    rem  = prod % dvs;
    if (2 * rem >= dvs) quo = quo + 1;
    r.saturated = 1'b0;
    if (!neg) begin
      if (quo > 128'h7FFF_FFFF_FFFF_FFFF) begin
        r.integral  = RES_MAX;
        r.saturated = 1'b1;
      end else begin
        r.integral = quo[63:0];
      end
    end else begin
      if (quo > 128'h8000_0000_0000_0000) begin
        r.integral  = RES_MIN;
        r.saturated = 1'b1;
      end else begin
        r.integral = ~quo[63:0] + 64'd1;
      end
    end
    return r;
  endfunction

  // Weight one accepted sample; on the end point queue the run's integral
  function automatic void accumulate_sample(input logic signed [SAMPLE_W-1:0] f);
    longint      fv;
    int unsigned n;
    int unsigned i;
    int unsigned m;
    bit          closes_run;
    fv = f;
    n  = eff_intervals(icnt_q);
    i  = grid_index;
    closes_run = (i >= n);
    if (closes_run) i = n;
    if (mode_q == MODE_TRAP) begin
      trapezoid_acc += (i == 0 || i == n) ? fv : 2 * fv;
    end else begin
      m = n[0] ? n - 1 : n;
      if (m > 0 && i <= m) begin
        if (i == 0 || i == m) simpson_acc += fv;
        else if (i[0]) simpson_acc += 4 * fv;
        else simpson_acc += 2 * fv;
      end
      // odd count: the last interval is a trapezoid panel
      if (n[0] && i >= m) trapezoid_acc += fv;
    end
    if (!closes_run) begin
      grid_index = i + 1;
    end else begin
      expected_integrals.push_back(scale_integral(simpson_acc, trapezoid_acc, n));
      simpson_acc   = 0;
      trapezoid_acc = 0;
      grid_index    = 0;
    end
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_MODE:     mode_q    = data[0];
      CFG_X_START:  x_start_q = data;
      CFG_X_END:    x_end_q   = data;
      CFG_INTERVAL: icnt_q    = data[ICNT_W-1:0];
      default:      mode_q    = mode_q;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send(input logic [SAMPLE_W-1:0] v);
    pending_samples.push_back(v);
  endtask

  task automatic push_samples(input int unsigned count);
    repeat (count) pending_samples.push_back(pick_value());
  endtask

  // Wait until every sample is taken and every integral has come back
  task automatic settle();
    while (pending_samples.size() != 0 || in_chan.valid || expected_integrals.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sample driver: hold a beat until taken, then gap or advance
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_chan.valid  <= 1'b0;
      in_chan.sample <= '0;
      src_gap = 0;
    end else begin
      if (in_chan.valid && in_chan.ready)
        accumulate_sample(in_chan.sample);
      if (!in_chan.valid || in_chan.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          in_chan.valid <= 1'b0;
        end else if (pending_samples.size() != 0) begin
          in_chan.valid  <= 1'b1;
          in_chan.sample <= pending_samples.pop_front();
          src_gap = pick_gap(idle_en);
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: check each beat against the oldest expected integral
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      sink_stall = 0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (expected_integrals.size() == 0) begin
          report_mismatch($sformatf("integral %h with none expected", out_chan.integral));
        end else begin
          want = expected_integrals.pop_front();
          if (out_chan.integral !== want.integral)
            report_mismatch($sformatf("integral %h, expected %h",
                                      out_chan.integral, want.integral));
          if (out_chan.saturated !== want.saturated)
            report_mismatch($sformatf("saturated %b, expected %b",
                                      out_chan.saturated, want.saturated));
        end
        sink_stall = pick_gap(idle_en);
      end else if (sink_stall > 0) begin
        sink_stall--;
      end else if (idle_en && $urandom_range(0, 15) == 0) begin
        sink_stall = pick_gap(idle_en);
      end
      out_chan.ready <= (sink_stall == 0);
    end
  end

  initial begin
    logic [CFG_W-1:0] wdata;
    int unsigned      n_eff;
    int unsigned      burst;

    rst_n <= 1'b0;
    cfg_we    = 1'b0;
    cfg_index = CFG_MODE;
    cfg_wdata = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: trapezoid, bounds 0 to 1.0, one interval
    send(32'h7FFF_FFFF);
    send(32'h8000_0000);
    settle();

    // Half-way quotients round away from zero
    write_reg(CFG_X_END, 32'd1);
    send(32'd1);
    send(32'd0);
    send(32'hFFFF_FFFF);
    send(32'd0);
    settle();

    // Zero count acts as one interval; Simpson then has only the trapezoid panel
    write_reg(CFG_MODE, MODE_SIMPSON);
    write_reg(CFG_INTERVAL, 32'd0);
    write_reg(CFG_X_START, 32'hFFFF_0000);
    write_reg(CFG_X_END, 32'h0003_0000);
    send(32'h0001_8000);
    send(32'hFFFE_0000);
    settle();

    // Even count: Simpson panels only
    write_reg(CFG_INTERVAL, 32'd4);
    send(32'h0000_0000);
    send(32'h0001_0000);
    send(32'h0004_0000);
    send(32'hFFF7_0000);
    send(32'h7FFF_FFFF);
    settle();

    // Odd count with reversed bounds: Simpson panels plus a trapezoid tail
    write_reg(CFG_INTERVAL, 32'd3);
    write_reg(CFG_X_START, 32'h7FFF_FFFF);
    write_reg(CFG_X_END, 32'h8000_0000);
    send(32'h0002_0000);
    send(32'h8000_0000);
    send(32'h7FFF_FFFF);
    send(32'hFFFF_FFFF);
    settle();

    // Widest bounds; start a long run, then cut the count so the next
    // sample closes it with interior weights and the result overflows
    write_reg(CFG_MODE, MODE_TRAP);
    write_reg(CFG_X_START, 32'h8000_0000);
    write_reg(CFG_X_END, 32'h7FFF_FFFF);
    write_reg(CFG_INTERVAL, 32'd65536);
    repeat (3) send(32'h7FFF_FFFF);
    settle();
    write_reg(CFG_INTERVAL, 32'd1);
    send(32'h7FFF_FFFF);
    settle();

    // Same with Simpson over an oversized count, toward the negative limit
    write_reg(CFG_MODE, MODE_SIMPSON);
    write_reg(CFG_INTERVAL, 32'h0001_FFFF);
    repeat (3) send(32'h8000_0000);
    settle();
    write_reg(CFG_INTERVAL, 32'd1);
    send(32'h8000_0000);
    settle();

    // One long run with an odd count, streamed without idling
    idle_en = 1'b0;
    write_reg(CFG_X_START, pick_value());
    write_reg(CFG_X_END, pick_value());
    write_reg(CFG_INTERVAL, 32'd255);
    push_samples(256);
    settle();

    // Random settings between bursts; bursts mostly finish runs, some stop
    // mid-run so the next settings apply to a run in progress
    while (random_samples < RANDOM_ITEMS) begin
      idle_en = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 3) != 0) begin
        wdata    = ($urandom_range(0, 3) == 0) ? $urandom() : '0;
        wdata[0] = 1'($urandom_range(0, 1));
        write_reg(CFG_MODE, wdata);
      end
      if ($urandom_range(0, 3) != 0) write_reg(CFG_X_START, pick_value());
      if ($urandom_range(0, 3) != 0) write_reg(CFG_X_END, pick_value());
      if ($urandom_range(0, 3) != 0) begin
        wdata = ($urandom_range(0, 3) == 0) ? $urandom() : '0;
        wdata[ICNT_W-1:0] = pick_count();
        write_reg(CFG_INTERVAL, wdata);
      end
      n_eff = eff_intervals(icnt_q);
      if (n_eff > 64) begin
        burst = $urandom_range(1, 8);
      end else begin
        burst = (grid_index >= n_eff) ? 1 : n_eff - grid_index + 1;
        burst += $urandom_range(0, 3) * (n_eff + 1);
        if ($urandom_range(0, 4) == 0) burst += $urandom_range(1, n_eff);
      end
      push_samples(burst);
      random_samples += burst;
      settle();
    end

    if (mismatch_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

### numeric_integration_1d.f
+incdir+hw/rtl
hw/rtl/nint_pkg.sv
hw/rtl/nint_if.sv
hw/rtl/nint_scale.sv
hw/rtl/numeric_integration_1d.sv
tb/sv/tb_numeric_integration_1d.sv
